// File: src/dfiir_pkg.sv
package dfiir_pkg;

  localparam int MAX_TAPS_DEFAULT = 512;

  localparam int MODE_W      = 2;
  localparam int INDEX_W     = 9;
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int ORDER_W     = 9;
  localparam int LINE_W      = 40;
  localparam int FRAC_BITS   = 14;
  localparam int PROD_W      = LINE_W + COEF_W;
  localparam int TERM_W      = PROD_W - FRAC_BITS;
  localparam int CFG_INDEX_W = 2;
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [MODE_W-1:0] MODE_FILTER   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_NUM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_DEN = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_NUM_ORDER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEN_ORDER = 2'd1;

  typedef struct packed {
    logic [MODE_W-1:0]          kind;
    logic [INDEX_W-1:0]         idx;
    logic signed [SAMPLE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [ORDER_W-1:0] num_order;
    logic [ORDER_W-1:0] den_order;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } eng_status_t;

endpackage

// File: src/direct_form_two_iir_filter_core.sv
// channel  | direction | handshake          | payload
// s_       | in        | s_tvalid/s_tready  | tdata: coef_index, value; tuser: mode
// m_       | out       | m_tvalid/m_tready  | tdata: sample_out; tuser: clipped
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (order registers)
//
// a sample holds the back end for the feedback and feedforward walks over the delay
// line ram through one multiplier, one tap a cycle
// coefficient loads go straight from the queue to their ram; a four-item queue sits between front and back
// after reset the delay line is cleared with s_tready low
// a pending result holds in its output register while the back end goes on
module direct_form_two_iir_filter_core #(
  parameter int MAX_TAPS = dfiir_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [dfiir_pkg::S_TDATA_W-1:0]    s_tdata,   // coef_index, value
  input  logic [dfiir_pkg::MODE_W-1:0]       s_tuser,   // mode
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [dfiir_pkg::M_TDATA_W-1:0]    m_tdata,   // sample_out
  output logic                               m_tuser,   // clipped
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dfiir_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [dfiir_pkg::ORDER_W-1:0]      cfg_data
);

  import dfiir_pkg::*;

  cfg_t                       cfg;
  eng_status_t                status;
  item_t                      q_item;
  logic                       q_valid;
  logic                       q_ready;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_clip;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_order <= '0;
      cfg.den_order <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_ORDER: cfg.num_order <= cfg_data;
        REG_DEN_ORDER: cfg.den_order <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dfiir_front #(.MAX_TAPS(MAX_TAPS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .status   (status),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  dfiir_engine #(.MAX_TAPS(MAX_TAPS)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (out_sample),
    .out_clip   (out_clip)
  );

  assign m_tdata = out_sample;
  assign m_tuser = out_clip;

endmodule

// File: src/dfiir_ram.sv
module dfiir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/dfiir_front.sv
module dfiir_front #(
  parameter int MAX_TAPS = dfiir_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dfiir_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [dfiir_pkg::MODE_W-1:0]     s_tuser,
  input  dfiir_pkg::eng_status_t           status,
  output logic                             q_valid,
  input  logic                             q_ready,
  output dfiir_pkg::item_t                 q_item
);

  import dfiir_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             fifo [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  item_t             in_item;
  logic              keep;
  logic              push;
  logic              pop;

  always_comb begin
    in_item.kind  = s_tuser;
    in_item.idx   = s_tdata[INDEX_W-1:0];
    in_item.value = s_tdata[INDEX_W+SAMPLE_W-1:INDEX_W];
    case (s_tuser)
      MODE_FILTER:   keep = 1'b1;
      MODE_LOAD_NUM: keep = 32'(in_item.idx) < MAX_TAPS;
      MODE_LOAD_DEN: keep = 32'(in_item.idx) < MAX_TAPS;
      default:       keep = 1'b0;
    endcase
  end

  assign s_tready = (count != CNT_W'(QUEUE_DEPTH)) && !status.clearing;
  assign push     = s_tvalid && s_tready && keep;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_item;
    end
  end

endmodule

// File: src/dfiir_engine.sv
module dfiir_engine #(
  parameter int MAX_TAPS = dfiir_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dfiir_pkg::cfg_t                     cfg,
  input  logic                                q_valid,
  output logic                                q_ready,
  input  dfiir_pkg::item_t                    q_item,
  output dfiir_pkg::eng_status_t              status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dfiir_pkg::SAMPLE_W-1:0] out_sample,
  output logic                                out_clip
);

  import dfiir_pkg::*;

  localparam int ADDR_W = $clog2(MAX_TAPS);
  localparam int LEN_W  = $clog2(MAX_TAPS + 1);
  localparam int ACC_W  = TERM_W + LEN_W;
  localparam int QUO_W  = ACC_W - FRAC_BITS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FB    = 3'd2;
  localparam logic [2:0] ST_STORE = 3'd3;
  localparam logic [2:0] ST_FF    = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]                 state;
  logic [ADDR_W-1:0]          clr_addr;
  logic [ADDR_W-1:0]          wp;
  logic [LEN_W-1:0]           len;
  logic [LEN_W-1:0]           ntaps;
  logic [LEN_W-1:0]           limit;
  logic [ADDR_W-1:0]          tap;
  logic [ADDR_W-1:0]          ptr;
  logic                       issuing;
  logic                       v1;
  logic                       v2;
  logic                       first1;
  logic                       first2;
  logic signed [SAMPLE_W-1:0] samp;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  logic [LEN_W-1:0]           ntaps_cfg;
  logic [LEN_W-1:0]           mtaps_cfg;
  logic [LEN_W-1:0]           len_cfg;
  logic [ADDR_W-1:0]          wp_start;
  logic [ADDR_W-1:0]          ptr_inc;
  logic                       last_issue;
  logic                       pop;
  logic                       start_sample;

  logic                       num_we;
  logic                       den_we;
  logic [ADDR_W-1:0]          coef_waddr;
  logic [COEF_W-1:0]          num_q;
  logic [COEF_W-1:0]          den_q;
  logic                       dl_we;
  logic [ADDR_W-1:0]          dl_waddr;
  logic [LINE_W-1:0]          dl_wdata;
  logic [LINE_W-1:0]          dl_q;

  logic signed [LINE_W-1:0]   a_op;
  logic signed [COEF_W-1:0]   c_op;
  logic signed [ACC_W-1:0]    term;
  logic                       w_fits;
  logic signed [LINE_W-1:0]   w_sat;
  logic signed [QUO_W-1:0]    quo;
  logic                       q_fits;
  logic signed [SAMPLE_W-1:0] y_sat;

  // orders at or above the table size clamp to the last tap
  assign ntaps_cfg = (32'(cfg.num_order) >= MAX_TAPS) ? LEN_W'(MAX_TAPS)
                   : LEN_W'(cfg.num_order) + LEN_W'(1);
  assign mtaps_cfg = (32'(cfg.den_order) >= MAX_TAPS) ? LEN_W'(MAX_TAPS)
                   : LEN_W'(cfg.den_order) + LEN_W'(1);
  assign len_cfg   = (ntaps_cfg > mtaps_cfg) ? ntaps_cfg : mtaps_cfg;
  assign wp_start  = (LEN_W'(wp) >= len_cfg) ? '0 : wp;

  assign ptr_inc    = (LEN_W'(ptr) + LEN_W'(1) == len) ? '0 : ptr + ADDR_W'(1);
  assign last_issue = (LEN_W'(tap) + LEN_W'(1) == limit);

  assign q_ready         = (state == ST_IDLE);
  assign pop             = q_valid && q_ready;
  assign start_sample    = pop && (q_item.kind == MODE_FILTER);
  assign status.clearing = (state == ST_CLEAR);

  assign num_we     = pop && (q_item.kind == MODE_LOAD_NUM);
  assign den_we     = pop && (q_item.kind == MODE_LOAD_DEN);
  assign coef_waddr = ADDR_W'(q_item.idx);

  assign dl_we    = (state == ST_CLEAR) || (state == ST_STORE);
  assign dl_waddr = (state == ST_CLEAR) ? clr_addr : wp;
  assign dl_wdata = (state == ST_CLEAR) ? '0 : w_sat;

  dfiir_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_num_ram (
    .clk   (clk),
    .we    (num_we),
    .waddr (coef_waddr),
    .wdata (q_item.value),
    .raddr (tap),
    .rdata (num_q)
  );

  dfiir_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_den_ram (
    .clk   (clk),
    .we    (den_we),
    .waddr (coef_waddr),
    .wdata (q_item.value),
    .raddr (tap),
    .rdata (den_q)
  );

  dfiir_ram #(.WIDTH(LINE_W), .DEPTH(MAX_TAPS)) u_line_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (ptr),
    .rdata (dl_q)
  );

  // first feedback tap scales the input sample instead of a line entry
  always_comb begin
    a_op = (state == ST_FB && first1)
         ? {{(LINE_W-SAMPLE_W){samp[SAMPLE_W-1]}}, samp} : dl_q;
    c_op = (state == ST_FB) ? den_q : num_q;
    term = (state == ST_FB && first2) ? ACC_W'(prod) : ACC_W'(prod >>> FRAC_BITS);
  end

  always_comb begin
    w_fits = (&acc[ACC_W-1:LINE_W-1]) || (~|acc[ACC_W-1:LINE_W-1]);
    if (w_fits) begin
      w_sat = acc[LINE_W-1:0];
    end else if (acc[ACC_W-1]) begin
      w_sat = {1'b1, {(LINE_W-1){1'b0}}};
    end else begin
      w_sat = {1'b0, {(LINE_W-1){1'b1}}};
    end
  end

  // divide by the fraction scale, rounding toward zero
  always_comb begin
    quo    = acc[ACC_W-1:FRAC_BITS]
           + QUO_W'(acc[ACC_W-1] && (|acc[FRAC_BITS-1:0]));
    q_fits = (&quo[QUO_W-1:SAMPLE_W-1]) || (~|quo[QUO_W-1:SAMPLE_W-1]);
    if (q_fits) begin
      y_sat = quo[SAMPLE_W-1:0];
    end else if (quo[QUO_W-1]) begin
      y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      wp        <= '0;
      len       <= '0;
      ntaps     <= '0;
      limit     <= '0;
      tap       <= '0;
      ptr       <= '0;
      issuing   <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(MAX_TAPS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start_sample) begin
            wp      <= wp_start;
            len     <= len_cfg;
            ntaps   <= ntaps_cfg;
            limit   <= mtaps_cfg;
            tap     <= '0;
            ptr     <= wp_start;
            issuing <= 1'b1;
            state   <= ST_FB;
          end
        end
        ST_FB, ST_FF: begin
          if (issuing) begin
            tap <= tap + ADDR_W'(1);
            ptr <= ptr_inc;
            if (last_issue) begin
              issuing <= 1'b0;
            end
          end else if (!v1 && !v2) begin
            state <= (state == ST_FB) ? ST_STORE : ST_OUT;
          end
        end
        ST_STORE: begin
          tap     <= '0;
          ptr     <= wp;
          limit   <= ntaps;
          issuing <= 1'b1;
          state   <= ST_FF;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            wp        <= (wp == '0) ? ADDR_W'(len - LEN_W'(1)) : wp - ADDR_W'(1);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    first1 <= (tap == '0);
    first2 <= first1;
    prod   <= PROD_W'(a_op) * PROD_W'(c_op);
    if (start_sample) begin
      samp <= q_item.value;
    end
    if (v2) begin
      if (first2) begin
        acc <= term;
      end else if (state == ST_FB) begin
        acc <= acc - term;
      end else begin
        acc <= acc + term;
      end
    end
    if (state == ST_OUT && (!out_valid || out_ready)) begin
      out_sample <= y_sat;
      out_clip   <= !q_fits;
    end
  end

  a_walk_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FB || state == ST_FF) |-> (LEN_W'(wp) < len && LEN_W'(ptr) < len))
    else $error("walk position outside the active delay line");

  a_issue_in_walk: assert property (@(posedge clk) disable iff (rst)
    issuing |-> ((state == ST_FB || state == ST_FF) && LEN_W'(tap) < limit))
    else $error("tap issued outside a walk or past its count");

  a_store_then_ff: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE) |=> (state == ST_FF && issuing && tap == '0))
    else $error("feedforward walk did not follow the line write");

  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_valid && !out_ready) |=> (state == ST_OUT && out_valid))
    else $error("result overwritten while still pending");

endmodule

// File: tb/dfiir_checker.sv
module dfiir_checker
  import dfiir_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [S_TDATA_W-1:0]     s_tdata,   // coef_index, value
  input  logic [MODE_W-1:0]        s_tuser,   // mode
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [M_TDATA_W-1:0]     m_tdata,   // sample_out
  input  logic                     m_tuser,   // clipped
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ORDER_W-1:0]       cfg_data,
  output int                       fail_count,
  output int                       pending,
  output int                       results_seen,
  output int                       clips_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS = MAX_TAPS_DEFAULT;
  localparam longint LINE_TOP = 64'sd549755813887;
  localparam longint LINE_BOT = -64'sd549755813888;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clip;
  } filtered_t;

  logic signed [COEF_W-1:0] num_coef [TAPS];
  logic signed [COEF_W-1:0] den_coef [TAPS];
  logic signed [LINE_W-1:0] line_mem [TAPS];
  int unsigned              wpos;
  logic [ORDER_W-1:0]       num_ord;
  logic [ORDER_W-1:0]       den_ord;
  filtered_t                predicted_outputs [$];

  function automatic filtered_t filter_sample(logic signed [SAMPLE_W-1:0] x);
    int unsigned ntaps;
    int unsigned mtaps;
    int unsigned span;
    int unsigned p;
    longint acc;
    longint y;
    longint q;
    filtered_t r;
    ntaps = int'(num_ord) + 1;
    mtaps = int'(den_ord) + 1;
    span = (ntaps > mtaps) ? ntaps : mtaps;
    if (wpos >= span) wpos = 0;
    // feedback part of the recursion
    acc = longint'(x) * longint'(den_coef[0]);
    for (int k = 1; k < mtaps; k++) begin
      p = (wpos + k) % span;
      acc -= (longint'(line_mem[p]) * longint'(den_coef[k])) >>> FRAC_BITS;
    end
    if (acc > LINE_TOP) acc = LINE_TOP;
    if (acc < LINE_BOT) acc = LINE_BOT;
    line_mem[wpos] = LINE_W'(acc);
    y = 0;
    for (int k = 0; k < ntaps; k++) begin
      p = (wpos + k) % span;
      y += (longint'(line_mem[p]) * longint'(num_coef[k])) >>> FRAC_BITS;
    end
    wpos = (wpos == 0) ? span - 1 : wpos - 1;
    // truncate toward zero, then saturate
    q = y / (longint'(1) <<< FRAC_BITS);
    r.clip = 1'b0;
    if (q > 32767) begin
      q = 32767;
      r.clip = 1'b1;
    end else if (q < -32768) begin
      q = -32768;
      r.clip = 1'b1;
    end
    r.sample = SAMPLE_W'(q);
    return r;
  endfunction

  function automatic void log_mismatch(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: mismatch: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    filtered_t oldest;
    logic [INDEX_W-1:0] idx;
    logic signed [SAMPLE_W-1:0] val;
    if (rst) begin
      wpos = 0;
      num_ord = '0;
      den_ord = '0;
      for (int k = 0; k < TAPS; k++) line_mem[k] = '0;
      predicted_outputs.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (m_tuser) clips_seen++;
        if (predicted_outputs.size() == 0) begin
          log_mismatch($sformatf("result %0d (clipped %0b) with nothing predicted",
                                 $signed(m_tdata), m_tuser));
        end else begin
          oldest = predicted_outputs.pop_front();
          if (m_tdata !== oldest.sample)
            log_mismatch($sformatf("sample_out expected %0d, got %0d",
                                   oldest.sample, $signed(m_tdata)));
          if (m_tuser !== oldest.clip)
            log_mismatch($sformatf("clipped expected %0b, got %0b", oldest.clip, m_tuser));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_ORDER: num_ord = cfg_data;
          REG_DEN_ORDER: den_ord = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        idx = s_tdata[INDEX_W-1:0];
        val = s_tdata[INDEX_W +: SAMPLE_W];
        case (s_tuser)
          MODE_FILTER:   predicted_outputs.push_back(filter_sample(val));
          MODE_LOAD_NUM: num_coef[idx] = val;
          MODE_LOAD_DEN: den_coef[idx] = val;
          default: ;
        endcase
      end
    end
    pending = predicted_outputs.size();
  end

endmodule

// File: tb/tb_direct_form_two_iir_filter_core.sv
module tb_direct_form_two_iir_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dfiir_pkg::*;

  localparam int TAPS = MAX_TAPS_DEFAULT;
  localparam int SETTLE_CYCLES = 2 * TAPS + 100;
  localparam int HOLD_CYCLES = 400;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum int { PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH } pace_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;   // coef_index, value
  logic [MODE_W-1:0]      s_tuser = '0;   // mode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;        // sample_out
  logic                   m_tuser;        // clipped
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ORDER_W-1:0]     cfg_data = '0;

  int fail_count;
  int pending;
  int results_seen;
  int clips_seen;

  int send_idle = 0;
  int recv_stall = 0;
  bit hold_toggle = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  bit num_known [TAPS];
  bit den_known [TAPS];
  int samples_sent = 0;
  int loads_sent = 0;
  int ignored_sent = 0;
  int settings_run = 0;

  direct_form_two_iir_filter_core uut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  dfiir_checker watch (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .results_seen, .clips_seen
  );

  always #5 clk = ~clk;

  initial begin
    #(20ms);
    $display("DONE: errors detected");
    $finish;
  end

  // output side, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic offer(logic [MODE_W-1:0] kind, logic [INDEX_W-1:0] idx,
                       logic signed [SAMPLE_W-1:0] val);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {{(S_TDATA_W - SAMPLE_W - INDEX_W){1'b0}}, val, idx};
    do @(posedge clk); while (!s_tready);
    case (kind)
      MODE_FILTER: samples_sent++;
      MODE_LOAD_NUM: begin
        num_known[idx] = 1'b1;
        loads_sent++;
      end
      MODE_LOAD_DEN: begin
        den_known[idx] = 1'b1;
        loads_sent++;
      end
      default: ignored_sent++;
    endcase
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [ORDER_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic settle();
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_coef(int lim, int wild_pct);
    int r;
    r = $urandom_range(99);
    if (r < wild_pct) return SAMPLE_W'($urandom);
    if (r < 3 * wild_pct) lim = 4096;
    return SAMPLE_W'(int'($urandom_range(2 * lim)) - lim);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 16'sh7FFF;
    if (r < 16) return 16'sh8000;
    if (r < 40) return SAMPLE_W'(int'($urandom_range(400)) - 200);
    return SAMPLE_W'($urandom);
  endfunction

  task automatic run_phase(int n_ord, int d_ord, int count, pace_t pace, bit squeeze);
    int r;
    int span;
    int n_lim;
    int d_lim;
    int done;
    bit squeezed;
    logic [MODE_W-1:0] kind;
    logic [INDEX_W-1:0] idx;
    case (pace)
      PACE_FULL: begin
        send_idle = 0;
        recv_stall = 0;
      end
      PACE_SEND_GAPS: begin
        send_idle = 86;
        recv_stall = 0;
      end
      PACE_RECV_STALLS: begin
        send_idle = 0;
        recv_stall = 86;
      end
      default: begin
        send_idle = 19;
        recv_stall = 19;
      end
    endcase
    settle();
    write_reg(REG_NUM_ORDER, ORDER_W'(n_ord));
    write_reg(REG_DEN_ORDER, ORDER_W'(d_ord));
    cfg_valid <= 1'b0;
    settings_run++;
    span = ((n_ord > d_ord) ? n_ord : d_ord) + 1;
    n_lim = 16384 / (n_ord + 1) + 1;
    d_lim = 12000 / (d_ord + 1) + 1;
    // every tap in use must hold a coefficient before the first sample
    for (int k = 0; k <= n_ord; k++)
      if (!num_known[k]) offer(MODE_LOAD_NUM, INDEX_W'(k), pick_coef(n_lim, 0));
    if (!den_known[0])
      offer(MODE_LOAD_DEN, '0, SAMPLE_W'(int'($urandom_range(32767)) - 16384));
    for (int k = 1; k <= d_ord; k++)
      if (!den_known[k]) offer(MODE_LOAD_DEN, INDEX_W'(k), pick_coef(d_lim, 0));
    done = 0;
    squeezed = 1'b0;
    while (done < count) begin
      if (squeeze && !squeezed && done >= count / 3) begin
        hold_toggle = ~hold_toggle;
        squeezed = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 68) begin
        offer(MODE_FILTER, INDEX_W'($urandom), pick_sample());
        done++;
      end else if (r < 94) begin
        kind = $urandom_range(1) ? MODE_LOAD_NUM : MODE_LOAD_DEN;
        idx = $urandom_range(1) ? INDEX_W'($urandom_range(span - 1)) : INDEX_W'($urandom);
        if (kind == MODE_LOAD_NUM) offer(kind, idx, pick_coef(n_lim, 6));
        else if (idx == 0) offer(kind, idx, SAMPLE_W'($urandom));
        else offer(kind, idx, pick_coef(d_lim, 6));
        done++;
      end else begin
        offer(MODE_UNUSED, INDEX_W'($urandom), SAMPLE_W'($urandom));
      end
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // zero-order identity, then gains that force saturation
    offer(MODE_LOAD_DEN, '0, 16'sd16384);
    offer(MODE_LOAD_NUM, '0, 16'sd16384);
    offer(MODE_FILTER, '0, 16'sh7FFF);
    offer(MODE_FILTER, 9'h1FF, 16'sh8000);
    offer(MODE_FILTER, '0, 16'sd0);
    offer(MODE_FILTER, '0, 16'sd1);
    offer(MODE_FILTER, '0, -16'sd1);
    offer(MODE_LOAD_NUM, '0, 16'sh7FFF);
    offer(MODE_FILTER, '0, 16'sh7FFF);
    offer(MODE_FILTER, '0, 16'sh8000);
    offer(MODE_FILTER, '0, 16'sd100);
    offer(MODE_LOAD_DEN, '0, 16'sh8000);
    offer(MODE_FILTER, '0, 16'sd20000);
    offer(MODE_FILTER, '0, -16'sd20000);
    // half gain: negative results round toward zero
    offer(MODE_LOAD_NUM, '0, 16'sd8192);
    offer(MODE_LOAD_DEN, '0, 16'sd16384);
    offer(MODE_FILTER, '0, -16'sd3);
    offer(MODE_FILTER, '0, 16'sd3);
    offer(MODE_UNUSED, 9'h1FF, 16'shFFFF);
    offer(MODE_UNUSED, '0, 16'sd0);
    offer(MODE_LOAD_NUM, 9'h1FF, -16'sd1);
    offer(MODE_LOAD_DEN, 9'h1FF, 16'sh7FFF);
    offer(MODE_FILTER, 9'h155, 16'sd12345);
    s_tvalid <= 1'b0;

    // writes to unassigned register slots must change nothing
    settle();
    write_reg(REG_SPARE_LO, 9'h1FF);
    write_reg(REG_SPARE_HI, 9'h0AA);
    cfg_valid <= 1'b0;

    run_phase(1, 1, 55, PACE_SEND_GAPS, 1'b0);
    run_phase(4, 3, 45, PACE_RECV_STALLS, 1'b0);
    run_phase(0, 0, 35, PACE_BOTH, 1'b0);
    run_phase(40, 40, 12, PACE_FULL, 1'b0);
    run_phase(2, 6, 40, PACE_SEND_GAPS, 1'b0);
    run_phase(7, 0, 40, PACE_RECV_STALLS, 1'b0);
    run_phase(0, 9, 40, PACE_BOTH, 1'b0);
    run_phase(40, 0, 8, PACE_RECV_STALLS, 1'b0);
    run_phase(3, 3, 60, PACE_FULL, 1'b1);
    run_phase(16, 12, 35, PACE_SEND_GAPS, 1'b0);
    run_phase(0, 40, 8, PACE_BOTH, 1'b0);
    run_phase(5, 2, 55, PACE_FULL, 1'b0);

    settle();
    $display("covered %0d samples (%0d results, %0d clipped) and %0d coefficient loads",
             samples_sent, results_seen, clips_seen, loads_sent);
    $display("over %0d order settings, with %0d items of the unused mode",
             settings_run, ignored_sent);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
src/dfiir_pkg.sv
src/dfiir_ram.sv
src/dfiir_front.sv
src/dfiir_engine.sv
src/direct_form_two_iir_filter_core.sv
tb/dfiir_checker.sv
tb/tb_direct_form_two_iir_filter_core.sv
